// File: sv/mafc_pkg.sv
// shared constants and types for the mpeg audio frame crc16 block
`timescale 1ns / 1ps
`default_nettype none

package mafc_pkg;

  // field widths
  localparam int CRC_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int NBITS_W = 4;
  localparam int POS_W   = 3;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_FIRST    = 3'd0;
  localparam logic [POS_W-1:0] POS_HDR_A    = 3'd2;
  localparam logic [POS_W-1:0] POS_HDR_B    = 3'd3;
  localparam logic [POS_W-1:0] POS_SATURATE = 3'd6;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_POLY = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INIT = 1'd1;

  // configuration reset values
  localparam logic [CRC_W-1:0] POLY_RESET = 16'h8005;
  localparam logic [CRC_W-1:0] INIT_RESET = 16'hffff;

  // one captured input request
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [NBITS_W-1:0] valid_bits;
    logic               frame_end;
  } item_t;

endpackage

`default_nettype wire

// File: sv/mpeg_audio_frame_crc16.sv
// top level: mpeg audio frame crc16 over a byte stream
//
//  channel | direction | payload                                   | marker
//  in_     | slave     | tdata[7:0] data_byte, tdata[11:8] valid_bits | tlast frame_end
//  out_    | master    | tdata[15:0] crc_value                     | tuser frame_too_short
//  cfg_    | write     | addr 0 polynomial, addr 1 initial value   | none
//
// one byte per cycle while in_tready is high; the per-byte crc network sits
// between the input register and the crc / result registers, so a frame
// result passes through the input register and then the result register.
// rst_n is synchronous, active low, and clears the valid flags, the byte
// position and the configuration registers; no clearing pass is needed.
// a stalled result holds its output register; bytes keep flowing until the
// next frame end meets a full output register, then in_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_frame_crc16 (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [mafc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [mafc_pkg::CRC_W-1:0]        cfg_wdata,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [15:0]                       in_tdata,   // data_byte, valid_bits, zero pad
  input  wire logic                              in_tlast,
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [15:0]                            out_tdata,  // crc_value
  output logic                                   out_tuser   // frame_too_short
);

  logic [mafc_pkg::CRC_W-1:0] poly_r;
  logic [mafc_pkg::CRC_W-1:0] init_r;

  mafc_pkg::item_t            item_r;
  logic                       item_valid_r;

  logic [mafc_pkg::CRC_W-1:0] crc_r,  crc_nxt;
  logic [mafc_pkg::POS_W-1:0] pos_r,  pos_nxt;

  logic                       out_valid_r;
  logic [mafc_pkg::CRC_W-1:0] out_crc_r;
  logic                       out_short_r;

  logic [mafc_pkg::CRC_W-1:0] crc_base;
  logic [mafc_pkg::CRC_W-1:0] crc_shifted;
  logic [mafc_pkg::CRC_W-1:0] crc_result;
  logic                       pos_included;
  logic                       advance;
  logic                       in_accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= mafc_pkg::POLY_RESET;
      init_r <= mafc_pkg::INIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mafc_pkg::CFG_POLY: poly_r <= cfg_wdata;
        mafc_pkg::CFG_INIT: init_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: the held byte moves on unless it closes a frame into a full output
  assign advance   = item_valid_r & (~item_r.frame_end | ~out_valid_r | out_tready);
  assign in_tready = ~item_valid_r | advance;
  assign in_accept = in_tvalid & in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.data_byte  <= in_tdata[7:0];
      item_r.valid_bits <= in_tdata[11:8];
      item_r.frame_end  <= in_tlast;
    end
  end

  // crc update for the held byte
  assign crc_base     = (pos_r == mafc_pkg::POS_FIRST) ? init_r : crc_r;
  assign pos_included = (pos_r == mafc_pkg::POS_HDR_A) || (pos_r == mafc_pkg::POS_HDR_B) ||
                        (pos_r >= mafc_pkg::POS_SATURATE);

  mafc_crc_step u_step (
    .crc_in     (crc_base),
    .poly       (poly_r),
    .data_byte  (item_r.data_byte),
    .valid_bits (item_r.valid_bits),
    .crc_out    (crc_shifted)
  );

  assign crc_result = pos_included ? crc_shifted : crc_base;

  // next frame state
  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    if (advance) begin
      if (item_r.frame_end) begin
        crc_nxt = init_r;
        pos_nxt = mafc_pkg::POS_FIRST;
      end else begin
        crc_nxt = crc_result;
        if (pos_r < mafc_pkg::POS_SATURATE) begin
          pos_nxt = pos_r + mafc_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= mafc_pkg::POS_FIRST;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && item_r.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_r.frame_end) begin
      out_crc_r   <= crc_result;
      out_short_r <= (pos_r < mafc_pkg::POS_SATURATE);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_crc_r;
  assign out_tuser  = out_short_r;

endmodule

`default_nettype wire

// File: sv/mafc_crc_step.sv
// crc16 update over the leading valid bits of one byte, msb first
`timescale 1ns / 1ps
`default_nettype none

module mafc_crc_step (
  input  wire logic [mafc_pkg::CRC_W-1:0]   crc_in,
  input  wire logic [mafc_pkg::CRC_W-1:0]   poly,
  input  wire logic [mafc_pkg::BYTE_W-1:0]  data_byte,
  input  wire logic [mafc_pkg::NBITS_W-1:0] valid_bits,
  output logic      [mafc_pkg::CRC_W-1:0]   crc_out
);

  // eight unrolled shift steps, each gated by the bit count
  always_comb begin
    logic [mafc_pkg::CRC_W-1:0] c;
    logic                       fb;
    c  = crc_in;
    fb = 1'b0;
    for (int i = 0; i < mafc_pkg::BYTE_W; i++) begin
      if (valid_bits > mafc_pkg::NBITS_W'(i)) begin
        fb = c[mafc_pkg::CRC_W-1] ^ data_byte[mafc_pkg::BYTE_W-1-i];
        c  = {c[mafc_pkg::CRC_W-2:0], 1'b0};
        if (fb) begin
          c = c ^ poly;
        end
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// File: sv/mafc_checker.sv
// port level checks for the mpeg audio frame crc16 block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mafc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result keeps its request and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // a fresh result follows a frame end taken through the input and result registers
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without frame end");

  // a draining output never stalls the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind mpeg_audio_frame_crc16 mafc_checker u_mafc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
